### rtl/ifla_pkg.sv
// Shared types and constants of the indexed free list allocator.
package ifla_pkg;

  localparam int IdxW   = 10;
  localparam int CountW = 11;
  localparam int CfgW   = 11;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Request modes as they arrive on the request channel.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Operation codes handed from the front to the back.
  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_REJECT = 2'd2;

  // Depth of the queue between front and back.
  localparam int QDepth = 2;
  localparam int QPtrW  = 1;

  typedef struct packed {
    logic            mode;
    logic [IdxW-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [IdxW-1:0]   granted_index;
    logic              ok;
    logic [CountW-1:0] in_use_count;
  } rsp_t;

  typedef struct packed {
    logic [1:0]      op;
    logic [IdxW-1:0] slot_index;
  } qentry_t;

endpackage

### rtl/ifla_stream_if.sv
// Valid/ready stream channel carrying one payload of a given type.
interface ifla_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/ifla_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
module ifla_front #(
  parameter int MaxSlots = 1024,
  parameter int LinkW    = $clog2(MaxSlots + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  ifla_pkg::req_t      req_payload_i,
  input  logic                clearing_i,
  input  logic [LinkW-1:0]    slot_count_i,
  output logic                q_valid_o,
  output ifla_pkg::qentry_t   q_entry_o,
  input  logic                q_pop_i
);
  import ifla_pkg::*;

  localparam int CmpW = (LinkW > IdxW) ? LinkW : IdxW;

  qentry_t           fifo_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]    cnt_q, cnt_d;
  logic              push;
  logic              in_range;
  qentry_t           entry;

  assign in_range = CmpW'(req_payload_i.slot_index) < CmpW'(slot_count_i);

  always_comb begin
    entry.slot_index = req_payload_i.slot_index;
    if (req_payload_i.mode == MODE_ALLOC) begin
      entry.op = OP_ALLOC;
    end else if (in_range) begin
      entry.op = OP_FREE;
    end else begin
      entry.op = OP_REJECT;
    end
  end

  // No request is taken while the link store is being rebuilt.
  assign req_ready_o = (cnt_q != (QPtrW+1)'(QDepth)) && !clearing_i;
  assign push        = req_valid_i && req_ready_o;
  assign q_valid_o   = (cnt_q != '0);
  assign q_entry_o   = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push    ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = q_pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= entry;
    end
  end

endmodule

### rtl/ifla_back.sv
// Back end: link store, list head, in-use count, rebuild sweep and response register.
module ifla_back #(
  parameter int MaxSlots = 1024,
  parameter int LinkW    = $clog2(MaxSlots + 1),
  parameter int AddrW    = $clog2(MaxSlots)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ifla_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                      q_valid_i,
  input  ifla_pkg::qentry_t         q_entry_i,
  output logic                      q_pop_o,
  output logic                      clearing_o,
  output logic [LinkW-1:0]          slot_count_o,
  output logic                      rsp_valid_o,
  input  logic                      rsp_ready_i,
  output ifla_pkg::rsp_t            rsp_payload_o
);
  import ifla_pkg::*;

  localparam int               ResetSlots = (1024 > MaxSlots) ? MaxSlots : 1024;
  localparam logic [LinkW-1:0] LinkNone   = LinkW'(MaxSlots);
  localparam logic [AddrW-1:0] LastAddr   = AddrW'(MaxSlots - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic [LinkW-1:0]  link_mem [MaxSlots];
  logic [LinkW-1:0]  rd_data_q;

  logic              state_q, state_d;
  logic              clr_busy_q, clr_busy_d;
  logic [AddrW-1:0]  clr_addr_q, clr_addr_d;
  logic [LinkW-1:0]  slot_count_q, slot_count_d;
  logic [LinkW-1:0]  head_q, head_d;
  logic [CountW-1:0] count_q, count_d;
  logic              rsp_valid_q, rsp_valid_d;
  rsp_t              rsp_q, rsp_d;

  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [LinkW-1:0]  mem_wdata;
  logic              rd_en;
  logic              out_free;
  logic              head_ok;
  logic [LinkW-1:0]  clr_next;
  logic [CfgW-1:0]   cfg_val;

  assign out_free      = !rsp_valid_q || rsp_ready_i;
  assign head_ok       = head_q < slot_count_q;
  assign clr_next      = LinkW'(clr_addr_q) + LinkW'(1);
  assign clearing_o    = clr_busy_q;
  assign slot_count_o  = slot_count_q;
  assign rsp_valid_o   = rsp_valid_q;
  assign rsp_payload_o = rsp_q;

  always_comb begin
    cfg_val = cfg_wdata_i;
    if (cfg_val == '0) begin
      cfg_val = CfgW'(1);
    end
    if (32'(cfg_val) > 32'(MaxSlots)) begin
      cfg_val = CfgW'(MaxSlots);
    end
  end

  always_comb begin
    state_d      = state_q;
    clr_busy_d   = clr_busy_q;
    clr_addr_d   = clr_addr_q;
    slot_count_d = slot_count_q;
    head_d       = head_q;
    count_d      = count_q;
    rsp_valid_d  = rsp_valid_q && !rsp_ready_i;
    rsp_d        = rsp_q;
    mem_we       = 1'b0;
    mem_waddr    = clr_addr_q;
    mem_wdata    = LinkNone;
    rd_en        = 1'b0;
    q_pop_o      = 1'b0;

    if (clr_busy_q) begin
      // Rebuild sweep: entry i links to i+1 while that slot is in the pool.
      mem_we     = 1'b1;
      mem_waddr  = clr_addr_q;
      mem_wdata  = (clr_next < slot_count_q) ? clr_next : LinkNone;
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == LastAddr) begin
        clr_busy_d = 1'b0;
      end
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i && out_free) begin
            q_pop_o = 1'b1;
            unique case (q_entry_i.op)
              OP_ALLOC: begin
                if (head_ok) begin
                  rd_en   = 1'b1;
                  state_d = ST_READ;
                end else begin
                  rsp_valid_d         = 1'b1;
                  rsp_d.granted_index = '0;
                  rsp_d.ok            = 1'b0;
                  rsp_d.in_use_count  = count_q;
                end
              end
              OP_FREE: begin
                mem_we    = 1'b1;
                mem_waddr = AddrW'(q_entry_i.slot_index);
                mem_wdata = head_ok ? head_q : LinkNone;
                head_d    = LinkW'(q_entry_i.slot_index);
                count_d   = (count_q == '0) ? count_q : count_q - CountW'(1);
                rsp_valid_d         = 1'b1;
                rsp_d.granted_index = '0;
                rsp_d.ok            = 1'b1;
                rsp_d.in_use_count  = count_d;
              end
              default: begin
                rsp_valid_d         = 1'b1;
                rsp_d.granted_index = '0;
                rsp_d.ok            = 1'b0;
                rsp_d.in_use_count  = count_q;
              end
            endcase
          end
        end
        ST_READ: begin
          // The head's link has arrived; it becomes the new head.
          if (out_free) begin
            head_d              = rd_data_q;
            count_d             = (count_q == CountMax) ? count_q : count_q + CountW'(1);
            rsp_valid_d         = 1'b1;
            rsp_d.granted_index = IdxW'(head_q);
            rsp_d.ok            = 1'b1;
            rsp_d.in_use_count  = count_d;
            state_d             = ST_IDLE;
          end
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end

    if (cfg_we_i) begin
      slot_count_d = LinkW'(cfg_val);
      clr_busy_d   = 1'b1;
      clr_addr_d   = '0;
      head_d       = '0;
      count_d      = '0;
      state_d      = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      clr_busy_q   <= 1'b1;
      clr_addr_q   <= '0;
      slot_count_q <= LinkW'(ResetSlots);
      head_q       <= '0;
      count_q      <= '0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_busy_q   <= clr_busy_d;
      clr_addr_q   <= clr_addr_d;
      slot_count_q <= slot_count_d;
      head_q       <= head_d;
      count_q      <= count_d;
      rsp_valid_q  <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= link_mem[AddrW'(head_q)];
    end
  end

endmodule

### rtl/indexed_free_list_allocator.sv
// Top level of the indexed free list slot allocator.
//
// Channels: req_i (sink) carries a mode and a slot index; rsp_o (source)
// returns one response per request with the granted index, a success flag
// and the in-use count after the request. Both use valid/ready, and a
// transfer happens when both are high at a rising clock edge. The pool size
// is written through cfg_we_i/cfg_wdata_i; the user must do so only while
// the block is idle, which it does not enforce. Requests enter a two-entry
// queue in the front end. An allocate that finds a slot passes through a
// read state, as the head's link is read from the synchronous link store
// before the new head is known; a free, a reject or a refused allocate is
// answered from the idle state, and no request is popped during the read
// state. After reset and after every write of the pool size, a sweep over
// all MaxSlots entries rebuilds the link store while req_i.ready is low.
// When the receiver stalls, the response register holds its result, the
// back end stops and the queue fills, after which req_i.ready drops.
module indexed_free_list_allocator #(
  parameter int MaxSlots = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ifla_pkg::CfgW-1:0] cfg_wdata_i,
  ifla_stream_if.sink               req_i,
  ifla_stream_if.source             rsp_o
);
  import ifla_pkg::*;

  localparam int LinkW = $clog2(MaxSlots + 1);
  localparam int AddrW = $clog2(MaxSlots);

  logic             q_valid;
  qentry_t          q_entry;
  logic             q_pop;
  logic             clearing;
  logic [LinkW-1:0] slot_count;
  req_t             req_payload;
  rsp_t             rsp_payload;

  assign req_payload   = req_i.payload;
  assign rsp_o.payload = rsp_payload;

  ifla_front #(
    .MaxSlots (MaxSlots),
    .LinkW    (LinkW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .req_ready_o   (req_i.ready),
    .req_payload_i (req_payload),
    .clearing_i    (clearing),
    .slot_count_i  (slot_count),
    .q_valid_o     (q_valid),
    .q_entry_o     (q_entry),
    .q_pop_i       (q_pop)
  );

  ifla_back #(
    .MaxSlots (MaxSlots),
    .LinkW    (LinkW),
    .AddrW    (AddrW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .q_valid_i     (q_valid),
    .q_entry_i     (q_entry),
    .q_pop_o       (q_pop),
    .clearing_o    (clearing),
    .slot_count_o  (slot_count),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_payload_o (rsp_payload)
  );

endmodule

### rtl/ifla_checker.sv
// Port-level checks of the allocator, attached to the top level by bind.
module ifla_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           cfg_we_i,
  input logic           req_ready_i,
  input logic           rsp_valid_i,
  input logic           rsp_ready_i,
  input ifla_pkg::rsp_t rsp_payload_i
);
  import ifla_pkg::*;

  // A response waiting for transfer stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response withdrawn before transfer");

  // A stalled response keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_payload_i))
    else $error("stalled response payload changed");

  // Writing the pool size starts a rebuild, so no request is taken next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !req_ready_i)
    else $error("request accepted during rebuild");

  // A failed request never hands out a slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_payload_i.ok |-> rsp_payload_i.granted_index == '0)
    else $error("failed request carries a granted index");

endmodule

bind indexed_free_list_allocator ifla_checker u_ifla_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_payload_i (rsp_o.payload)
);

### tb/tb_indexed_free_list_allocator.sv
// Self-checking testbench for the indexed free list allocator.
module tb_indexed_free_list_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import ifla_pkg::*;

  localparam int                PoolMax    = 1024;
  localparam logic [CountW-1:0] LinkNone   = CountW'(PoolMax);
  localparam int                CycleLimit = 500000;
  localparam int                PrintCap   = 30;

  // Shadow of the pool: its own link store, head, in-use count and pool size,
  // plus the responses still owed by the block in request order.
  class slot_pool_shadow;
    logic [CountW-1:0] link_mem [PoolMax];
    logic [CountW-1:0] head;
    logic [CountW-1:0] in_use;
    logic [CountW-1:0] pool_size;
    rsp_t              owed_responses [$];
    int mismatches, checked, grants, refusals, frees, rejects, sizes_seen;

    function void set_pool_size(logic [CfgW-1:0] value);
      if (value == 0) begin
        pool_size = CountW'(1);
      end else if (value > PoolMax) begin
        pool_size = CountW'(PoolMax);
      end else begin
        pool_size = value;
      end
      for (int i = 0; i < PoolMax; i++) begin
        link_mem[i] = (i + 1 < pool_size) ? CountW'(i + 1) : LinkNone;
      end
      head   = '0;
      in_use = '0;
      sizes_seen++;
    endfunction

    function rsp_t apply_request(req_t r);
      rsp_t e;
      e = '0;
      if (r.mode == MODE_ALLOC) begin
        // A head outside the pool means the list is empty.
        if (head < pool_size) begin
          e.granted_index = head[IdxW-1:0];
          e.ok            = 1'b1;
          head            = link_mem[head[IdxW-1:0]];
          if (in_use != CountMax) in_use++;
          grants++;
        end else begin
          refusals++;
        end
      end else begin
        if ({1'b0, r.slot_index} < pool_size) begin
          link_mem[r.slot_index] = (head < pool_size) ? head : LinkNone;
          head                   = {1'b0, r.slot_index};
          if (in_use != 0) in_use--;
          e.ok = 1'b1;
          frees++;
        end else begin
          rejects++;
        end
      end
      e.in_use_count = in_use;
      owed_responses.push_back(e);
      return e;
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= PrintCap) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task match_response(rsp_t got);
      rsp_t e;
      if (owed_responses.size() == 0) begin
        report($sformatf("response with nothing outstanding: index %0d ok %0b count %0d",
                         got.granted_index, got.ok, got.in_use_count));
        return;
      end
      e = owed_responses.pop_front();
      checked++;
      if (got.granted_index !== e.granted_index)
        report($sformatf("granted_index %0d, expected %0d", got.granted_index,
                         e.granted_index));
      if (got.ok !== e.ok)
        report($sformatf("ok %0b, expected %0b", got.ok, e.ok));
      if (got.in_use_count !== e.in_use_count)
        report($sformatf("in_use_count %0d, expected %0d", got.in_use_count,
                         e.in_use_count));
    endtask

    function int pending();
      return owed_responses.size();
    endfunction
  endclass

  logic            clk_i      = 1'b0;
  logic            rst_ni     = 1'b0;
  logic            cfg_we     = 1'b0;
  logic [CfgW-1:0] cfg_wdata  = '0;
  logic            src_valid  = 1'b0;
  req_t            src_req    = '0;
  logic            sink_ready = 1'b0;
  logic            no_idle    = 1'b0;
  int              cycle_count;
  logic [IdxW-1:0] held_slots [$];
  slot_pool_shadow pool;

  ifla_stream_if #(.payload_t(req_t)) req_if ();
  ifla_stream_if #(.payload_t(rsp_t)) rsp_if ();

  assign req_if.valid   = src_valid;
  assign req_if.payload = src_req;
  assign rsp_if.ready   = sink_ready;

  indexed_free_list_allocator #(
    .MaxSlots(PoolMax)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if.sink),
    .rsp_o       (rsp_if.source)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) sink_ready <= no_idle || ($urandom_range(99) >= 26);
    if (rst_ni && rsp_if.valid && rsp_if.ready) pool.match_response(rsp_if.payload);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timed out after %0d cycles.", cycle_count);
    $display("tb_indexed_free_list_allocator NOT OK");
    $finish;
  end

  // Offers one request and returns at the edge of its transfer, with valid
  // still high so that a following request can go out without a gap.
  task automatic send_request(input logic op_mode, input logic [IdxW-1:0] idx);
    req_t item;
    rsp_t e;
    item.mode       = op_mode;
    item.slot_index = idx;
    if (!no_idle && $urandom_range(99) < 26) begin
      src_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 26);
    end
    src_valid <= 1'b1;
    src_req   <= item;
    do @(posedge clk_i); while (!req_if.ready);
    e = pool.apply_request(item);
    if (op_mode == MODE_ALLOC && e.ok) held_slots.push_back(e.granted_index);
  endtask

  task automatic write_pool_size(input logic [CfgW-1:0] value);
    src_valid <= 1'b0;
    while (pool.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    pool.set_pool_size(value);
    held_slots.delete();
  endtask

  // Mostly allocations and returns of slots that are really held; the rest
  // are returns of arbitrary indexes, in range or not.
  task automatic run_random(input int count, input int alloc_pct);
    logic [IdxW-1:0] idx;
    int              pick;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < alloc_pct) begin
        send_request(MODE_ALLOC, IdxW'($urandom));
      end else if (held_slots.size() != 0 && $urandom_range(99) < 85) begin
        pick = $urandom_range(held_slots.size() - 1);
        idx  = held_slots[pick];
        held_slots.delete(pick);
        send_request(MODE_FREE, idx);
      end else if ($urandom_range(1) == 1) begin
        send_request(MODE_FREE, IdxW'($urandom));
      end else begin
        send_request(MODE_FREE, IdxW'($urandom_range(pool.pool_size)));
      end
    end
  endtask

  initial begin
    int phase_size [7];
    int phase_alloc [7];
    phase_size  = '{1024, 7, 1, 2, 300, 1025, 64};
    phase_alloc = '{60, 55, 50, 60, 70, 50, 55};
    pool = new;
    pool.set_pool_size(CfgW'(PoolMax));
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Full pool straight after reset: grants in order, a return of a slot
    // never handed out, and the highest index.
    send_request(MODE_ALLOC, 10'h3FF);
    send_request(MODE_ALLOC, 10'h000);
    send_request(MODE_ALLOC, 10'h155);
    send_request(MODE_FREE, 10'd1);
    send_request(MODE_ALLOC, 10'h2AA);
    send_request(MODE_FREE, 10'h3FF);
    send_request(MODE_ALLOC, 10'h000);
    send_request(MODE_FREE, 10'h000);
    send_request(MODE_FREE, 10'h3FF);

    // A size of zero is taken as one slot: empty pool, out-of-range returns,
    // the count held at zero and a slot pushed twice.
    write_pool_size(11'd0);
    send_request(MODE_ALLOC, 10'h000);
    send_request(MODE_ALLOC, 10'h3FF);
    send_request(MODE_FREE, 10'd1);
    send_request(MODE_FREE, 10'h3FF);
    send_request(MODE_FREE, 10'h000);
    send_request(MODE_FREE, 10'h000);
    send_request(MODE_ALLOC, 10'h000);

    // An oversized write is clipped to the full pool.
    write_pool_size(11'd2047);
    send_request(MODE_FREE, 10'h3FF);
    send_request(MODE_ALLOC, 10'h000);

    for (int p = 0; p < 7; p++) begin
      write_pool_size(CfgW'(phase_size[p]));
      no_idle <= (p == 3);
      run_random(200, phase_alloc[p]);
    end
    no_idle <= 1'b0;

    // Pushing the tail slot again closes the list into a loop, so allocation
    // never runs dry.
    write_pool_size(11'd3);
    send_request(MODE_FREE, 10'd2);
    repeat (20) send_request(MODE_ALLOC, IdxW'($urandom));
    send_request(MODE_FREE, 10'd0);
    send_request(MODE_FREE, 10'd1);

    src_valid <= 1'b0;
    while (pool.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Checked %0d responses over %0d pool sizes: %0d grants, %0d empty-pool refusals,",
             pool.checked, pool.sizes_seen, pool.grants, pool.refusals);
    $display("%0d returns taken and %0d out-of-range returns rejected; %0d mismatches.",
             pool.frees, pool.rejects, pool.mismatches);
    if (pool.mismatches == 0) begin
      $display("tb_indexed_free_list_allocator OK");
    end else begin
      $display("tb_indexed_free_list_allocator NOT OK");
    end
    $finish;
  end

endmodule

### files.f
rtl/ifla_pkg.sv
rtl/ifla_stream_if.sv
rtl/ifla_front.sv
rtl/ifla_back.sv
rtl/indexed_free_list_allocator.sv
rtl/ifla_checker.sv
tb/tb_indexed_free_list_allocator.sv
